@@ sv/dotq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dotq_pkg;

  localparam int MAX_OBSTACLES_DEF = 256;
  localparam int COORD_W   = 24;
  localparam int LEN_W     = 16;
  localparam int REACH_W   = 17;
  localparam int DSQ_W     = 34;   // hits only: dsq < reach^2 < 2^34
  localparam int RES_W     = DSQ_W + 1;
  localparam int ROOT_W    = 17;
  localparam int PEN_W     = 17;
  localparam int SLOT_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int ISQ_STAGES = DSQ_W / 2;
  // read + three eval stages + root stages, plus one for the accumulator
  localparam int DRAIN_CYC = 1 + 3 + ISQ_STAGES + 1;
  localparam int DRAIN_W   = $clog2(DRAIN_CYC);

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    REG_BODY = 2'd0,
    REG_STEP = 2'd1,
    REG_HEAD = 2'd2,
    REG_JUMP = 2'd3
  } reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  localparam logic [1:0] CLS_PASS  = 2'd0;
  localparam logic [1:0] CLS_STEP  = 2'd1;
  localparam logic [1:0] CLS_JUMP  = 2'd2;
  localparam logic [1:0] CLS_BLOCK = 2'd3;

  typedef struct packed {
    logic [1:0]                 action;
    logic signed [COORD_W-1:0]  query_x;
    logic signed [COORD_W-1:0]  query_z;
    logic signed [COORD_W-1:0]  foot_level;
    logic signed [COORD_W-1:0]  obstacle_x;
    logic signed [COORD_W-1:0]  obstacle_z;
    logic [LEN_W-1:0]           obstacle_radius;
    logic signed [COORD_W-1:0]  obstacle_base;
    logic [LEN_W-1:0]           obstacle_height;
    logic [1:0]                 obstacle_class;
  } req_t;

  typedef struct packed {
    logic [1:0]        worst_class;
    logic [SLOT_W-1:0] hit_slot;
    logic [PEN_W-1:0]  penetration;
    logic              dropped_append;
  } rsp_t;

  typedef struct packed {
    logic [LEN_W-1:0] body_radius;
    logic [LEN_W-1:0] step_over_height;
    logic [LEN_W-1:0] head_clearance;
    logic [LEN_W-1:0] jump_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] z;
    logic [LEN_W-1:0]          radius;
    logic signed [COORD_W-1:0] base;
    logic [LEN_W-1:0]          height;
    logic [1:0]                cls;
  } entry_t;

  typedef struct packed {
    logic [REACH_W-1:0] reach;
    logic [1:0]         grade;
  } sq_tag_t;

endpackage
`default_nettype wire

@@ sv/dotq_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dotq_table #(
  parameter int DEPTH  = dotq_pkg::MAX_OBSTACLES_DEF,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire dotq_pkg::entry_t  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output dotq_pkg::entry_t       rd_data
);

  dotq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ sv/dotq_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dotq_eval #(
  parameter int IDX_W = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_vld,
  input  wire logic [IDX_W-1:0]                     in_idx,
  input  wire dotq_pkg::entry_t                     ent,
  input  wire logic signed [dotq_pkg::COORD_W-1:0]  qx,
  input  wire logic signed [dotq_pkg::COORD_W-1:0]  qz,
  input  wire logic signed [dotq_pkg::COORD_W-1:0]  foot,
  input  wire dotq_pkg::cfg_t                       cfg,
  output logic                                      out_vld,
  output logic [IDX_W-1:0]                          out_idx,
  output dotq_pkg::sq_tag_t                         out_tag,
  output logic [dotq_pkg::DSQ_W-1:0]                out_dsq
);

  localparam int W = dotq_pkg::COORD_W + 1;
  localparam int P = 2 * W;

  // stage 1: deltas, reach, grade
  logic signed [W-1:0] top_lvl, step_lvl, head_lvl;
  logic [1:0]          grade;
  logic signed [W-1:0] dx1, dz1;
  logic [dotq_pkg::REACH_W-1:0] reach1;
  logic [1:0]          grade1;
  logic                vld1;
  logic [IDX_W-1:0]    idx1;

  always_comb begin
    top_lvl  = W'(ent.base) + $signed({9'b0, ent.height});
    step_lvl = W'(foot) + $signed({9'b0, cfg.step_over_height});
    head_lvl = W'(foot) + $signed({9'b0, cfg.head_clearance});
    priority if (top_lvl < step_lvl) begin
      grade = dotq_pkg::CLS_STEP;
    end else if (cfg.head_clearance != '0 && W'(ent.base) > head_lvl) begin
      grade = dotq_pkg::CLS_PASS;
    end else if (ent.cls == dotq_pkg::CLS_JUMP && ent.height <= cfg.jump_limit) begin
      grade = dotq_pkg::CLS_JUMP;
    end else if (ent.cls == dotq_pkg::CLS_PASS) begin
      grade = dotq_pkg::CLS_PASS;
    end else begin
      grade = dotq_pkg::CLS_BLOCK;
    end
  end

  always_ff @(posedge clk) begin
    dx1    <= W'(ent.x) - W'(qx);
    dz1    <= W'(ent.z) - W'(qz);
    reach1 <= dotq_pkg::REACH_W'(ent.radius) + dotq_pkg::REACH_W'(cfg.body_radius);
    grade1 <= grade;
    idx1   <= in_idx;
  end

  // stage 2: squares
  logic signed [P-1:0] px, pz;
  logic [P-2:0]        dx2, dz2;
  logic [dotq_pkg::DSQ_W-1:0] rr2;
  logic [dotq_pkg::REACH_W-1:0] reach2;
  logic [1:0]          grade2;
  logic                vld2;
  logic [IDX_W-1:0]    idx2;

  assign px = dx1 * dx1;
  assign pz = dz1 * dz1;

  always_ff @(posedge clk) begin
    dx2    <= px[P-2:0];
    dz2    <= pz[P-2:0];
    rr2    <= dotq_pkg::DSQ_W'(reach1) * dotq_pkg::DSQ_W'(reach1);
    reach2 <= reach1;
    grade2 <= grade1;
    idx2   <= idx1;
  end

  // stage 3: distance sum and overlap test; passable grades drop out here
  logic [P-1:0] dsq;
  logic         hit;

  assign dsq = P'(dx2) + P'(dz2);
  assign hit = vld2 && (dsq < P'(rr2)) && (grade2 != dotq_pkg::CLS_PASS);

  always_ff @(posedge clk) begin
    out_dsq       <= dsq[dotq_pkg::DSQ_W-1:0];
    out_tag.reach <= reach2;
    out_tag.grade <= grade2;
    out_idx       <= idx2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= hit;
    end
  end

endmodule
`default_nettype wire

@@ sv/dotq_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dotq_isqrt #(
  parameter int IDX_W = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_vld,
  input  wire logic [IDX_W-1:0]                   in_idx,
  input  wire dotq_pkg::sq_tag_t                  in_tag,
  input  wire logic [dotq_pkg::DSQ_W-1:0]         in_val,
  output logic                                    out_vld,
  output logic [IDX_W-1:0]                        out_idx,
  output dotq_pkg::sq_tag_t                       out_tag,
  output logic [dotq_pkg::ROOT_W-1:0]             out_root
);

  localparam int N  = dotq_pkg::ISQ_STAGES;
  localparam int DW = dotq_pkg::DSQ_W;
  localparam int RW = dotq_pkg::RES_W;

  // one result bit per stage, restoring digit method
  logic [DW-1:0]      rem [N+1];
  logic [RW-1:0]      res [N+1];
  logic               vld [N+1];
  logic [IDX_W-1:0]   idx [N+1];
  dotq_pkg::sq_tag_t  tag [N+1];

  assign rem[0] = in_val;
  assign res[0] = '0;
  assign vld[0] = in_vld;
  assign idx[0] = in_idx;
  assign tag[0] = in_tag;

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam logic [RW-1:0] BIT = RW'(1) << (DW - 2 - 2 * s);
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = res[s] + BIT;
    assign ge    = {1'b0, rem[s]} >= trial;

    always_ff @(posedge clk) begin
      rem[s+1] <= ge ? rem[s] - trial[DW-1:0] : rem[s];
      res[s+1] <= ge ? (res[s] >> 1) + BIT : res[s] >> 1;
      idx[s+1] <= idx[s];
      tag[s+1] <= tag[s];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end
  end

  assign out_vld  = vld[N];
  assign out_idx  = idx[N];
  assign out_tag  = tag[N];
  assign out_root = res[N][dotq_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

@@ sv/disc_obstacle_traversal_query.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Obstacle table with point query.
// req channel (req_valid/req_ready/req): one beat is clear, append or query.
//   Clear and append return nothing; an append to a full
//   table is dropped and sets the sticky dropped_append flag until a clear.
// rsp channel (rsp_valid/rsp_ready/rsp): one beat per query.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready, write
//   only while no query is in flight.
// A query reads one table entry per cycle from the obstacle memory port,
//   through a 3-stage distance/grade pipe and a 17-stage square-root pipe.
//   The next req beat can be taken at the same edge the result can first
//   be taken.
// A stalled rsp holds the result; a further query finishes its scan and
//   waits in ST_DONE until the output register frees up.
// Reset (synchronous) empties the table, clears the flag and the registers.
module disc_obstacle_traversal_query #(
  parameter int MAX_OBSTACLES = dotq_pkg::MAX_OBSTACLES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               req_valid,
  output logic                                    req_ready,
  input  wire dotq_pkg::req_t                     req,
  output logic                                    rsp_valid,
  input  wire logic                               rsp_ready,
  output dotq_pkg::rsp_t                          rsp,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [dotq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dotq_pkg::LEN_W-1:0]         cfg_data
);

  localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_OBSTACLES);
  localparam logic [31:0] NONE_SLOT = 32'(MAX_OBSTACLES);

  dotq_pkg::state_t state, state_next;
  dotq_pkg::cfg_t   cfg;

  logic [CNT_W-1:0] entry_count;
  logic             overflow_flag;
  logic [IDX_W-1:0] scan_idx;
  logic [dotq_pkg::DRAIN_W-1:0] drain_cnt;

  logic signed [dotq_pkg::COORD_W-1:0] qx, qz, foot;

  // running best
  logic [1:0]               worst;
  logic [dotq_pkg::PEN_W-1:0] deepest;
  logic [IDX_W-1:0]         best_idx;
  logic                     found;

  logic req_fire, rd_en, wr_en, out_load;
  dotq_pkg::entry_t wr_entry, rd_entry;

  assign req_fire = req_valid && req_ready;
  assign cfg_ready = 1'b1;

  // ---------------- control ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      dotq_pkg::ST_IDLE: begin
        if (req_fire && req.action == dotq_pkg::ACT_QUERY) begin
          state_next = (entry_count == '0) ? dotq_pkg::ST_DRAIN : dotq_pkg::ST_SCAN;
        end
      end
      dotq_pkg::ST_SCAN: begin
        if (CNT_W'(scan_idx) == entry_count - CNT_W'(1)) begin
          state_next = dotq_pkg::ST_DRAIN;
        end
      end
      dotq_pkg::ST_DRAIN: begin
        if (drain_cnt == dotq_pkg::DRAIN_W'(dotq_pkg::DRAIN_CYC - 1)) begin
          state_next = dotq_pkg::ST_DONE;
        end
      end
      dotq_pkg::ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = dotq_pkg::ST_IDLE;
        end
      end
      default: state_next = dotq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state == dotq_pkg::ST_IDLE);
    rd_en     = (state == dotq_pkg::ST_SCAN);
    out_load  = (state == dotq_pkg::ST_DONE) && (!rsp_valid || rsp_ready);
    wr_en     = req_fire && req.action == dotq_pkg::ACT_APPEND && entry_count != FULL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dotq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      drain_cnt <= '0;
    end else begin
      if (state == dotq_pkg::ST_IDLE) begin
        scan_idx <= '0;
      end else if (rd_en) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (state == dotq_pkg::ST_DRAIN) begin
        drain_cnt <= drain_cnt + dotq_pkg::DRAIN_W'(1);
      end else begin
        drain_cnt <= '0;
      end
    end
  end

  // table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      overflow_flag <= 1'b0;
    end else if (req_fire) begin
      if (req.action == dotq_pkg::ACT_CLEAR) begin
        entry_count   <= '0;
        overflow_flag <= 1'b0;
      end else if (req.action == dotq_pkg::ACT_APPEND) begin
        if (entry_count == FULL) begin
          overflow_flag <= 1'b1;
        end else begin
          entry_count <= entry_count + CNT_W'(1);
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dotq_pkg::reg_t'(cfg_index))
        dotq_pkg::REG_BODY: cfg.body_radius      <= cfg_data;
        dotq_pkg::REG_STEP: cfg.step_over_height <= cfg_data;
        dotq_pkg::REG_HEAD: cfg.head_clearance   <= cfg_data;
        dotq_pkg::REG_JUMP: cfg.jump_limit       <= cfg_data;
        default: ;
      endcase
    end
  end

  // query operands held for the scan
  always_ff @(posedge clk) begin
    if (req_fire && req.action == dotq_pkg::ACT_QUERY) begin
      qx   <= req.query_x;
      qz   <= req.query_z;
      foot <= req.foot_level;
    end
  end

  // ---------------- datapath ----------------
  always_comb begin
    wr_entry.x      = req.obstacle_x;
    wr_entry.z      = req.obstacle_z;
    wr_entry.radius = req.obstacle_radius;
    wr_entry.base   = req.obstacle_base;
    wr_entry.height = req.obstacle_height;
    wr_entry.cls    = req.obstacle_class;
  end

  // writes only in idle, reads only in scan: no same-entry overlap
  dotq_table #(
    .DEPTH  (MAX_OBSTACLES),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_count[IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (scan_idx),
    .rd_data (rd_entry)
  );

  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
  end

  logic                       ev_vld;
  logic [IDX_W-1:0]           ev_idx;
  dotq_pkg::sq_tag_t          ev_tag;
  logic [dotq_pkg::DSQ_W-1:0] ev_dsq;

  dotq_eval #(.IDX_W(IDX_W)) u_eval (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (rd_vld),
    .in_idx  (rd_idx),
    .ent     (rd_entry),
    .qx      (qx),
    .qz      (qz),
    .foot    (foot),
    .cfg     (cfg),
    .out_vld (ev_vld),
    .out_idx (ev_idx),
    .out_tag (ev_tag),
    .out_dsq (ev_dsq)
  );

  logic                        iq_vld;
  logic [IDX_W-1:0]            iq_idx;
  dotq_pkg::sq_tag_t           iq_tag;
  logic [dotq_pkg::ROOT_W-1:0] iq_root;

  dotq_isqrt #(.IDX_W(IDX_W)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (ev_vld),
    .in_idx   (ev_idx),
    .in_tag   (ev_tag),
    .in_val   (ev_dsq),
    .out_vld  (iq_vld),
    .out_idx  (iq_idx),
    .out_tag  (iq_tag),
    .out_root (iq_root)
  );

  // accumulate: hardest grade, then deepest, first index on ties
  logic [dotq_pkg::PEN_W-1:0] pen;
  logic                       better;

  assign pen    = dotq_pkg::PEN_W'(iq_tag.reach) - dotq_pkg::PEN_W'(iq_root);
  assign better = (iq_tag.grade > worst) || (iq_tag.grade == worst && pen > deepest);

  always_ff @(posedge clk) begin
    if (rst) begin
      worst   <= '0;
      deepest <= '0;
      found   <= 1'b0;
    end else if (req_fire && req.action == dotq_pkg::ACT_QUERY) begin
      worst   <= '0;
      deepest <= '0;
      found   <= 1'b0;
    end else if (iq_vld && better) begin
      worst   <= iq_tag.grade;
      deepest <= pen;
      found   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (iq_vld && better) begin
      best_idx <= iq_idx;
    end
  end

  // output register
  logic [31:0] slot_wide;
  assign slot_wide = found ? 32'(best_idx) : NONE_SLOT;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.worst_class    <= worst;
      rsp.hit_slot       <= slot_wide[dotq_pkg::SLOT_W-1:0];
      rsp.penetration    <= found ? deepest : '0;
      rsp.dropped_append <= overflow_flag;
    end
  end

  // ---------------- checks ----------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL)
    else $error("entry count above table depth");

  a_pipe_in_query: assert property (@(posedge clk) disable iff (rst)
    (iq_vld || ev_vld || rd_vld) |->
      (state == dotq_pkg::ST_SCAN || state == dotq_pkg::ST_DRAIN))
    else $error("pipeline beat outside a query");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    state == dotq_pkg::ST_DONE |-> !iq_vld && !ev_vld && !rd_vld)
    else $error("result taken before pipeline drained");

  a_found_class: assert property (@(posedge clk) disable iff (rst)
    found == (worst != dotq_pkg::CLS_PASS))
    else $error("found flag and worst class disagree");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !rd_en)
    else $error("table write during scan");

endmodule
`default_nettype wire

@@ test/disc_obstacle_traversal_query_test.sv @@
`timescale 1ns / 1ps
module disc_obstacle_traversal_query_test;

  localparam int TABLE_DEPTH = 256;
  localparam int STALL_LIMIT = 20000;   // covers the worst query plus long stalls
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // request side
  logic req_valid = 1'b0;
  logic req_ready;
  dotq_pkg::req_t req = '0;

  // response side
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  dotq_pkg::rsp_t rsp;

  // register write side
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [dotq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dotq_pkg::LEN_W-1:0] cfg_data = '0;

  disc_obstacle_traversal_query DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the obstacle table and walker settings.
  dotq_pkg::entry_t shadow_table [TABLE_DEPTH];
  int               shadow_count;
  bit               shadow_dropped;
  dotq_pkg::cfg_t   walker;

  dotq_pkg::req_t pending_beats [$];
  dotq_pkg::rsp_t expected_answers [$];
  int   error_count;
  int   idle_cycles;
  bit   stimulus_done;

  // pending register write, handed from the initial block to the driver
  bit                         cfg_request;
  dotq_pkg::reg_t             cfg_req_index;
  logic [dotq_pkg::LEN_W-1:0] cfg_req_data;

  function automatic void queue_beat(dotq_pkg::req_t b);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res, bitpos;
    res = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos >>= 2;
    while (bitpos != 0) begin
      if (v >= res + bitpos) begin
        v -= res + bitpos;
        res = (res >> 1) + bitpos;
      end else begin
        res >>= 1;
      end
      bitpos >>= 2;
    end
    return res;
  endfunction

  // Traversal ladder: first matching rule wins.
  function automatic logic [1:0] traversal_grade(dotq_pkg::entry_t e, longint foot);
    longint base_l, height_l;
    base_l = e.base;
    height_l = e.height;
    if (base_l + height_l < foot + longint'(walker.step_over_height))
      return dotq_pkg::CLS_STEP;
    if (walker.head_clearance != 0 && base_l > foot + longint'(walker.head_clearance))
      return dotq_pkg::CLS_PASS;
    if (e.cls == dotq_pkg::CLS_JUMP && height_l <= longint'(walker.jump_limit))
      return dotq_pkg::CLS_JUMP;
    if (e.cls == dotq_pkg::CLS_PASS) return dotq_pkg::CLS_PASS;
    return dotq_pkg::CLS_BLOCK;
  endfunction

  // Apply one accepted beat to the shadow table; queue an answer for queries.
  function automatic void apply_beat(dotq_pkg::req_t b);
    dotq_pkg::rsp_t ans;
    longint dx, dz, foot;
    longint unsigned dsq, reach, pen, deepest;
    logic [1:0] worst, g;
    int slot;
    case (dotq_pkg::act_t'(b.action))
      dotq_pkg::ACT_CLEAR: begin
        shadow_count = 0;
        shadow_dropped = 1'b0;
      end
      dotq_pkg::ACT_APPEND: begin
        if (shadow_count >= TABLE_DEPTH) shadow_dropped = 1'b1;
        else begin
          shadow_table[shadow_count] = '{b.obstacle_x, b.obstacle_z, b.obstacle_radius,
                                         b.obstacle_base, b.obstacle_height,
                                         b.obstacle_class};
          shadow_count++;
        end
      end
      dotq_pkg::ACT_QUERY: begin
        worst = dotq_pkg::CLS_PASS;
        deepest = 0;
        slot = TABLE_DEPTH;
        foot = b.foot_level;
        for (int i = 0; i < shadow_count; i++) begin
          dx = longint'(shadow_table[i].x) - longint'(b.query_x);
          dz = longint'(shadow_table[i].z) - longint'(b.query_z);
          dsq = dx * dx + dz * dz;
          reach = longint'(shadow_table[i].radius) + longint'(walker.body_radius);
          if (dsq >= reach * reach) continue;
          g = traversal_grade(shadow_table[i], foot);
          if (g == dotq_pkg::CLS_PASS) continue;
          pen = reach - floor_root(dsq);
          if (g > worst || (g == worst && pen > deepest)) begin
            worst = g;
            deepest = pen;
            slot = i;
          end
        end
        ans.worst_class = worst;
        ans.hit_slot = slot[dotq_pkg::SLOT_W-1:0];
        ans.penetration = deepest[dotq_pkg::PEN_W-1:0];
        ans.dropped_append = shadow_dropped;
        expected_answers.insert(expected_answers.size(), ans);
      end
      default: ;  // unused action code is ignored
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Mostly short gaps, occasionally long ones, sometimes none.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Request driver
  int req_gap;
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_gap <= 0;
    end else if (req_valid && !req_ready) begin
      // hold the beat
    end else if (req_gap > 0) begin
      req_valid <= 1'b0;
      req_gap <= req_gap - 1;
    end else if (pending_beats.size() != 0 && !cfg_request) begin
      req <= pending_beats.pop_front();
      req_valid <= 1'b1;
      req_gap <= gap_length();
    end else begin
      req_valid <= 1'b0;
    end
  end

  // Register write driver: only used while the block is idle.
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_valid <= 1'b0;
      cfg_request <= 1'b0;
    end else if (cfg_request && !cfg_valid) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_req_index;
      cfg_data <= cfg_req_data;
    end
  end

  // Response ready toggling
  int rsp_gap;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_gap <= 0;
    end else if (rsp_gap > 0) begin
      rsp_ready <= 1'b0;
      rsp_gap <= rsp_gap - 1;
    end else begin
      rsp_ready <= 1'b1;
      if (rsp_valid && rsp_ready) rsp_gap <= gap_length();
    end
  end

  // Monitor: predict on accepted requests, compare accepted responses.
  dotq_pkg::rsp_t want;
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) apply_beat(req);
      if (cfg_valid && cfg_ready) begin
        case (dotq_pkg::reg_t'(cfg_index))
          dotq_pkg::REG_BODY: walker.body_radius = cfg_data;
          dotq_pkg::REG_STEP: walker.step_over_height = cfg_data;
          dotq_pkg::REG_HEAD: walker.head_clearance = cfg_data;
          dotq_pkg::REG_JUMP: walker.jump_limit = cfg_data;
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = expected_answers.pop_front();
          if (rsp.worst_class !== want.worst_class)
            report_mismatch("worst_class", rsp.worst_class, want.worst_class);
          if (rsp.hit_slot !== want.hit_slot)
            report_mismatch("hit_slot", rsp.hit_slot, want.hit_slot);
          if (rsp.penetration !== want.penetration)
            report_mismatch("penetration", rsp.penetration, want.penetration);
          if (rsp.dropped_append !== want.dropped_append)
            report_mismatch("dropped_append", rsp.dropped_append, want.dropped_append);
        end
      end
    end
  end

  // Watchdog: counts cycles with no beat on any channel.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (!stimulus_done) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** disc_obstacle_traversal_query: FAILED **");
        $finish;
      end
    end
  end

  // Random signed coordinate, mostly near the origin so obstacles overlap.
  function automatic logic [dotq_pkg::COORD_W-1:0] near_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return dotq_pkg::COORD_W'($urandom());
    return dotq_pkg::COORD_W'($signed($urandom_range(0, 4096)) - 2048);
  endfunction

  function automatic dotq_pkg::req_t random_obstacle();
    dotq_pkg::req_t b;
    b = '0;
    b.action = dotq_pkg::ACT_APPEND;
    b.obstacle_x = near_coord();
    b.obstacle_z = near_coord();
    b.obstacle_radius = ($urandom_range(0, 9) == 0) ? dotq_pkg::LEN_W'($urandom())
                        : dotq_pkg::LEN_W'($urandom_range(0, 1200));
    b.obstacle_base = ($urandom_range(0, 9) == 0) ? dotq_pkg::COORD_W'($urandom())
                      : dotq_pkg::COORD_W'($signed($urandom_range(0, 1024)) - 512);
    b.obstacle_height = ($urandom_range(0, 9) == 0) ? dotq_pkg::LEN_W'($urandom())
                        : dotq_pkg::LEN_W'($urandom_range(0, 1024));
    b.obstacle_class = 2'($urandom_range(0, 3));
    // some unused query fields still get random bits
    b.query_x = dotq_pkg::COORD_W'($urandom());
    b.foot_level = dotq_pkg::COORD_W'($urandom());
    return b;
  endfunction

  function automatic dotq_pkg::req_t random_query();
    dotq_pkg::req_t b;
    b = '0;
    b.action = dotq_pkg::ACT_QUERY;
    b.query_x = near_coord();
    b.query_z = near_coord();
    b.foot_level = ($urandom_range(0, 9) == 0) ? dotq_pkg::COORD_W'($urandom())
                   : dotq_pkg::COORD_W'($signed($urandom_range(0, 1024)) - 512);
    b.obstacle_x = dotq_pkg::COORD_W'($urandom());
    b.obstacle_radius = dotq_pkg::LEN_W'($urandom());
    b.obstacle_class = 2'($urandom_range(0, 3));
    return b;
  endfunction

  function automatic dotq_pkg::req_t make_beat(logic [1:0] a);
    dotq_pkg::req_t b;
    b = '0;
    b.action = a;
    return b;
  endfunction

  // Wait for all answers, then the block's drain latency, before touching registers.
  task automatic settle();
    while (pending_beats.size() != 0 || req_valid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (TABLE_DEPTH + 40) @(posedge clk);
  endtask

  task automatic write_reg(dotq_pkg::reg_t idx, logic [dotq_pkg::LEN_W-1:0] val);
    cfg_req_index = idx;
    cfg_req_data = val;
    cfg_request = 1'b1;
    while (cfg_request) @(posedge clk);
  endtask

  task automatic program_walker(logic [dotq_pkg::LEN_W-1:0] body,
                                logic [dotq_pkg::LEN_W-1:0] step,
                                logic [dotq_pkg::LEN_W-1:0] head,
                                logic [dotq_pkg::LEN_W-1:0] jump);
    settle();
    write_reg(dotq_pkg::REG_BODY, body);
    write_reg(dotq_pkg::REG_STEP, step);
    write_reg(dotq_pkg::REG_HEAD, head);
    write_reg(dotq_pkg::REG_JUMP, jump);
  endtask

  dotq_pkg::req_t b;
  int issued;
  int table_size;
  initial begin
    shadow_count = 0;
    shadow_dropped = 1'b0;
    walker = '0;
    error_count = 0;
    idle_cycles = 0;
    stimulus_done = 1'b0;
    cfg_request = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: query of an empty table at reset settings, then extremes.
    queue_beat(make_beat(dotq_pkg::ACT_QUERY));
    settle();
    program_walker(16'd256, 16'd64, 16'd512, 16'd300);
    // one obstacle of each class around the origin
    for (int c = 0; c < 4; c++) begin
      b = make_beat(dotq_pkg::ACT_APPEND);
      b.obstacle_x = dotq_pkg::COORD_W'(c * 40);
      b.obstacle_radius = 16'd400;
      b.obstacle_height = 16'd200;
      b.obstacle_class = 2'(c);
      queue_beat(b);
    end
    // short obstacle: step-over rule
    b = make_beat(dotq_pkg::ACT_APPEND);
    b.obstacle_radius = 16'd100;
    b.obstacle_height = 16'd10;
    b.obstacle_class = dotq_pkg::CLS_BLOCK;
    queue_beat(b);
    // overhead obstacle: duck-under rule
    b = make_beat(dotq_pkg::ACT_APPEND);
    b.obstacle_radius = 16'd100;
    b.obstacle_base = 24'sd2000;
    b.obstacle_class = dotq_pkg::CLS_BLOCK;
    queue_beat(b);
    // extreme corners
    b = make_beat(dotq_pkg::ACT_APPEND);
    b.obstacle_x = 24'h7FFFFF;
    b.obstacle_z = 24'h800000;
    b.obstacle_radius = 16'hFFFF;
    b.obstacle_base = 24'h800000;
    b.obstacle_height = 16'hFFFF;
    b.obstacle_class = dotq_pkg::CLS_JUMP;
    queue_beat(b);
    b = make_beat(dotq_pkg::ACT_QUERY);
    queue_beat(b);
    b.query_x = 24'h7FFFFF;
    b.query_z = 24'h800000;
    b.foot_level = 24'h7FFFFF;
    queue_beat(b);
    b.foot_level = 24'h800000;
    queue_beat(b);
    b = make_beat(dotq_pkg::ACT_QUERY);
    b.query_x = 24'sd60;
    b.foot_level = -24'sd100;
    queue_beat(b);
    queue_beat(make_beat(ACT_UNUSED));
    queue_beat(make_beat(dotq_pkg::ACT_CLEAR));
    queue_beat(make_beat(dotq_pkg::ACT_QUERY));

    // Full table: overflowing appends set the sticky flag; a clear drops it.
    settle();
    program_walker(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < TABLE_DEPTH + 2; i++) queue_beat(random_obstacle());
    queue_beat(random_query());
    queue_beat(make_beat(dotq_pkg::ACT_CLEAR));
    queue_beat(random_query());

    // Random phases: build a small table, then mix queries and noise.
    issued = 0;
    for (int phase = 0; issued < 600; phase++) begin
      case (phase % 4)
        0: program_walker(16'd0, 16'd0, 16'd0, 16'd0);
        1: program_walker(dotq_pkg::LEN_W'($urandom_range(0, 600)),
                          dotq_pkg::LEN_W'($urandom_range(0, 300)),
                          dotq_pkg::LEN_W'($urandom_range(0, 800)),
                          dotq_pkg::LEN_W'($urandom_range(0, 800)));
        2: program_walker(dotq_pkg::LEN_W'($urandom()), dotq_pkg::LEN_W'($urandom()),
                          dotq_pkg::LEN_W'($urandom()), dotq_pkg::LEN_W'($urandom()));
        default: program_walker(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
      endcase
      queue_beat(make_beat(dotq_pkg::ACT_CLEAR));
      table_size = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(0, 14);
      for (int i = 0; i < table_size; i++) begin
        queue_beat(random_obstacle());
        issued++;
      end
      for (int i = 0; i < 25; i++) begin
        case ($urandom_range(0, 19))
          0: queue_beat(make_beat(ACT_UNUSED));
          1: queue_beat(random_obstacle());
          default: queue_beat(random_query());
        endcase
        issued++;
      end
    end

    settle();
    stimulus_done = 1'b1;
    if (error_count == 0) begin
      $display("** disc_obstacle_traversal_query: PASSED **");
    end else begin
      $display("** disc_obstacle_traversal_query: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/dotq_pkg.sv
sv/dotq_table.sv
sv/dotq_eval.sv
sv/dotq_isqrt.sv
sv/disc_obstacle_traversal_query.sv
test/disc_obstacle_traversal_query_test.sv
